FILE: src/vu_meter_decay_peak_hold_defines.svh
// Assertion macros shared by the checker of the meter block.
// No dependencies; included by the files that assert.
`ifndef VU_METER_DECAY_PEAK_HOLD_DEFINES_SVH
`define VU_METER_DECAY_PEAK_HOLD_DEFINES_SVH

// Implication checked in the same cycle.
`define VMDP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define VMDP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/vmdp_pkg.sv
// Package of the meter block: types, codes, reset constants and the dB table.
// No dependencies; used by every other file of the block but the defines header.
`timescale 1ns / 1ps

package vmdp_pkg;

  localparam int CHANNELS_DEF = 8;

  typedef logic        [1:0]  op_t;
  typedef logic        [1:0]  reg_idx_t;
  typedef logic signed [6:0]  db_t;
  typedef logic        [12:0] hold_t;
  typedef logic        [3:0]  fall_t;

  localparam op_t OP_LEVEL   = 2'd0;
  localparam op_t OP_REFRESH = 2'd1;
  localparam op_t OP_TICK    = 2'd2;

  localparam reg_idx_t REG_HOLD_MS      = 2'd0;
  localparam reg_idx_t REG_RED_ABOVE    = 2'd1;
  localparam reg_idx_t REG_YELLOW_FLOOR = 2'd2;

  typedef enum logic [1:0] {
    ZONE_GREEN  = 2'd0,
    ZONE_YELLOW = 2'd1,
    ZONE_RED    = 2'd2,
    ZONE_GRAY   = 2'd3
  } zone_t;

  localparam db_t        FLOOR_DB       = -7'sd60;
  localparam db_t        RED_ABOVE_RST  = -7'sd2;
  localparam db_t        YELLOW_RST     = -7'sd12;
  localparam hold_t      HOLD_MS_RST    = 13'd2300;
  localparam hold_t      HOLD_MAX       = 13'h1FFF;
  localparam logic [3:0] STEP_MAX       = 4'd13;

  // Result of the per-item level computation.
  typedef struct packed {
    db_t   target;
    fall_t fall;
    db_t   level;
    logic  peak_upd;
  } calc_t;

  function automatic db_t db_of_step(logic [3:0] step);
    db_t db;
    unique case (step)
      4'd0, 4'd1: db = -7'sd60;
      4'd2:       db = -7'sd55;
      4'd3:       db = -7'sd50;
      4'd4:       db = -7'sd45;
      4'd5:       db = -7'sd40;
      4'd6:       db = -7'sd35;
      4'd7:       db = -7'sd30;
      4'd8:       db = -7'sd25;
      4'd9:       db = -7'sd20;
      4'd10:      db = -7'sd15;
      4'd11:      db = -7'sd10;
      4'd12:      db = -7'sd5;
      4'd13:      db = 7'sd0;
      default:    db = FLOOR_DB;
    endcase
    return db;
  endfunction

  // Red is tested first, so crossed thresholds leave yellow empty.
  function automatic zone_t zone_of(db_t db, db_t red_above, db_t yellow_floor);
    zone_t z;
    priority if (db > red_above) z = ZONE_RED;
    else if (db >= yellow_floor) z = ZONE_YELLOW;
    else                         z = ZONE_GREEN;
    return z;
  endfunction

endpackage

FILE: src/vmdp_if.sv
// Handshake interfaces of the meter block: input items, results, register writes.
// Depends on vmdp_pkg.
`timescale 1ns / 1ps

interface vmdp_item_if;
  logic            valid;
  logic            ready;
  vmdp_pkg::op_t   operation;
  logic [2:0]      channel;
  logic [3:0]      step;
  logic            muted;

  modport source (output valid, operation, channel, step, muted, input ready);
  modport sink   (input valid, operation, channel, step, muted, output ready);
endinterface

interface vmdp_result_if;
  logic              valid;
  logic              ready;
  logic [2:0]        out_channel;
  vmdp_pkg::db_t     level_db;
  logic [1:0]        level_zone;
  vmdp_pkg::db_t     peak_db;
  logic [1:0]        peak_zone;
  logic              peak_updated;

  modport source (output valid, out_channel, level_db, level_zone, peak_db, peak_zone,
                  peak_updated, input ready);
  modport sink   (input valid, out_channel, level_db, level_zone, peak_db, peak_zone,
                  peak_updated, output ready);
endinterface

interface vmdp_cfg_if;
  logic               valid;
  logic               ready;
  vmdp_pkg::reg_idx_t index;
  logic [12:0]        data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/vmdp_level_calc.sv
// Per-item level arithmetic: target lookup, fall decrement, falling bar and
// peak replace decision. Depends on vmdp_pkg.
`timescale 1ns / 1ps

module vmdp_level_calc (
  input  logic                 is_level,
  input  logic [3:0]           step,
  input  vmdp_pkg::db_t        shown,
  input  vmdp_pkg::db_t        target_old,
  input  vmdp_pkg::fall_t      fall_old,
  input  vmdp_pkg::db_t        peak,
  input  vmdp_pkg::hold_t      elapsed,
  input  vmdp_pkg::hold_t      hold_ms,
  output vmdp_pkg::calc_t      calc
);

  vmdp_pkg::db_t   target;
  logic signed [7:0] diff;
  logic [7:0]      mag;
  logic [8:0]      rounded;
  logic [12:0]     scaled;
  vmdp_pkg::fall_t fall;
  logic signed [7:0] dropped;
  vmdp_pkg::db_t   level;

  assign target = is_level ? vmdp_pkg::db_of_step(step) : target_old;

  // Divide by five with rounding: (mag + 2) * 13 / 64 is exact for mag up to 60.
  assign diff    = 8'(shown) - 8'(target);
  assign mag     = diff[7] ? 8'(-diff) : 8'(diff);
  assign rounded = {1'b0, mag} + 9'd2;
  assign scaled  = 13'(rounded) * 13'd13;
  assign fall    = is_level ? scaled[9:6] : fall_old;

  assign dropped = 8'(shown) - $signed({4'b0, fall});

  always_comb begin
    if (shown > target) begin
      if (dropped < 8'(vmdp_pkg::FLOOR_DB)) level = vmdp_pkg::FLOOR_DB;
      else                                  level = dropped[6:0];
    end else begin
      level = (target < vmdp_pkg::FLOOR_DB) ? vmdp_pkg::FLOOR_DB : target;
    end
  end

  assign calc.target   = target;
  assign calc.fall     = fall;
  assign calc.level    = level;
  assign calc.peak_upd = (elapsed > hold_ms) || (target > peak);

endmodule

FILE: src/vu_meter_decay_peak_hold.sv
// Multi-channel level meter with falling bars and peak hold. An item is either a
// new level step for a channel, a refresh that lets that channel's bar fall one
// more decrement, or a millisecond tick that ages every channel's hold counter.
// Level and refresh items give one result with the shown level, the held peak
// and their color zones; ticks, operation code 3, steps beyond 13 and channels
// not below CHANNELS give none. One item is accepted every clock cycle while input
// is not stalled: an item passes an input register, then a single stage of
// per-channel logic that updates the channel registers and loads the result
// register, which holds the result until it is taken. The rate is
// set by that one update stage;
// a result waiting in the output register stalls input only when the item behind
// it also has a result to deliver. All channel state is cleared by reset at once,
// with no clearing pass. Registers are written through the cfg port, always ready.
// Depends on vmdp_pkg, vmdp_if and vmdp_level_calc.
`timescale 1ns / 1ps

module vu_meter_decay_peak_hold #(
  parameter int CHANNELS = vmdp_pkg::CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  vmdp_item_if.sink     in_item,
  vmdp_result_if.source out_res,
  vmdp_cfg_if.sink      cfg_wr
);

  localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  vmdp_pkg::hold_t hold_ms_r;
  vmdp_pkg::db_t   red_above_r;
  vmdp_pkg::db_t   yellow_floor_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ms_r      <= vmdp_pkg::HOLD_MS_RST;
      red_above_r    <= vmdp_pkg::RED_ABOVE_RST;
      yellow_floor_r <= vmdp_pkg::YELLOW_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        vmdp_pkg::REG_HOLD_MS:      hold_ms_r      <= cfg_wr.data;
        vmdp_pkg::REG_RED_ABOVE:    red_above_r    <= cfg_wr.data[6:0];
        vmdp_pkg::REG_YELLOW_FLOOR: yellow_floor_r <= cfg_wr.data[6:0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic          item_v_r;
  vmdp_pkg::op_t op_r;
  logic [2:0]    ch_r;
  logic [3:0]    step_r;
  logic          muted_r;

  logic out_v_r;
  logic produces;
  logic is_tick;
  logic stage_go;

  always_comb begin
    is_tick  = (op_r == vmdp_pkg::OP_TICK);
    produces = item_v_r && ({29'd0, ch_r} < 32'(CHANNELS)) &&
               ((op_r == vmdp_pkg::OP_REFRESH) ||
                ((op_r == vmdp_pkg::OP_LEVEL) && (step_r <= vmdp_pkg::STEP_MAX)));
    stage_go = item_v_r && (!produces || !out_v_r || out_res.ready);
  end

  assign in_item.ready = !item_v_r || stage_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_item.ready) begin
      item_v_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_item.valid && in_item.ready) begin
      op_r    <= in_item.operation;
      ch_r    <= in_item.channel;
      step_r  <= in_item.step;
      muted_r <= in_item.muted;
    end
  end

  // Channel state.
  vmdp_pkg::db_t   shown_r   [CHANNELS];
  vmdp_pkg::db_t   target_r  [CHANNELS];
  vmdp_pkg::fall_t fall_r    [CHANNELS];
  vmdp_pkg::db_t   peak_r    [CHANNELS];
  vmdp_pkg::hold_t elapsed_r [CHANNELS];

  logic [CHW+2:0] ch_ext;
  logic [CHW-1:0] idx;

  assign ch_ext = {{CHW{1'b0}}, ch_r};
  assign idx    = ch_ext[CHW-1:0];

  vmdp_pkg::calc_t calc;

  vmdp_level_calc u_calc (
    .is_level   (op_r == vmdp_pkg::OP_LEVEL),
    .step       (step_r),
    .shown      (shown_r[idx]),
    .target_old (target_r[idx]),
    .fall_old   (fall_r[idx]),
    .peak       (peak_r[idx]),
    .elapsed    (elapsed_r[idx]),
    .hold_ms    (hold_ms_r),
    .calc       (calc)
  );

  logic          write_ch;
  vmdp_pkg::db_t peak_nxt;

  assign write_ch = stage_go && produces;
  assign peak_nxt = calc.peak_upd ? calc.level : peak_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        shown_r[c]   <= vmdp_pkg::FLOOR_DB;
        target_r[c]  <= vmdp_pkg::FLOOR_DB;
        fall_r[c]    <= '0;
        peak_r[c]    <= vmdp_pkg::FLOOR_DB;
        elapsed_r[c] <= vmdp_pkg::HOLD_MAX;
      end
    end else if (write_ch) begin
      shown_r[idx]  <= calc.level;
      target_r[idx] <= calc.target;
      fall_r[idx]   <= calc.fall;
      peak_r[idx]   <= peak_nxt;
      if (calc.peak_upd) begin
        elapsed_r[idx] <= '0;
      end
    end else if (stage_go && is_tick) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (elapsed_r[c] != vmdp_pkg::HOLD_MAX) begin
          elapsed_r[c] <= elapsed_r[c] + 13'd1;
        end
      end
    end
  end

  // Result register.
  logic [2:0]     res_ch_r;
  vmdp_pkg::db_t  res_level_r;
  vmdp_pkg::zone_t res_lzone_r;
  vmdp_pkg::db_t  res_peak_r;
  vmdp_pkg::zone_t res_pzone_r;
  logic           res_upd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (write_ch) begin
      out_v_r <= 1'b1;
    end else if (out_res.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (write_ch) begin
      res_ch_r    <= ch_r;
      res_level_r <= calc.level;
      res_lzone_r <= muted_r ? vmdp_pkg::ZONE_GRAY :
                     vmdp_pkg::zone_of(calc.level, red_above_r, yellow_floor_r);
      res_peak_r  <= peak_nxt;
      res_pzone_r <= vmdp_pkg::zone_of(peak_nxt, red_above_r, yellow_floor_r);
      res_upd_r   <= calc.peak_upd;
    end
  end

  assign out_res.valid        = out_v_r;
  assign out_res.out_channel  = res_ch_r;
  assign out_res.level_db     = res_level_r;
  assign out_res.level_zone   = res_lzone_r;
  assign out_res.peak_db      = res_peak_r;
  assign out_res.peak_zone    = res_pzone_r;
  assign out_res.peak_updated = res_upd_r;

endmodule

FILE: src/vmdp_checker.sv
// Port-level checker of the meter block, bound to the top level.
// Depends on vu_meter_decay_peak_hold_defines.svh and vmdp_pkg.
`timescale 1ns / 1ps
`include "vu_meter_decay_peak_hold_defines.svh"

module vmdp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input vmdp_pkg::db_t level_db,
  input vmdp_pkg::db_t peak_db,
  input logic [1:0]    peak_zone,
  input logic          peak_updated
);

  logic stalled;
  assign stalled = out_valid && !out_ready;

  `VMDP_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled,
                    out_valid && $stable(level_db) && $stable(peak_db),
                    "stalled result changed")
  `VMDP_ASSERT_NOW(a_level_range, clk, rst_n, out_valid,
                   (level_db >= vmdp_pkg::FLOOR_DB) && (level_db <= 7'sd0),
                   "level out of range")
  `VMDP_ASSERT_NOW(a_peak_follows, clk, rst_n, out_valid && peak_updated,
                   peak_db == level_db, "replaced peak differs from level")
  `VMDP_ASSERT_NOW(a_peak_zone, clk, rst_n, out_valid,
                   peak_zone != vmdp_pkg::ZONE_GRAY, "peak shown gray")

endmodule

bind vu_meter_decay_peak_hold vmdp_checker u_vmdp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .level_db     (out_res.level_db),
  .peak_db      (out_res.peak_db),
  .peak_zone    (out_res.peak_zone),
  .peak_updated (out_res.peak_updated)
);
